// ===== src/dle_etx_pkg.sv =====
// Shared types and constants for the DLE/ETX frame receiver.
// No dependencies; imported by every module of the block.
package dle_etx_pkg;

  // framing symbols
  localparam logic [7:0] SYM_DLE  = 8'h10;
  localparam logic [7:0] SYM_ETX  = 8'h03;
  localparam logic [7:0] SYM_ACK  = 8'h06;
  localparam logic [7:0] SYM_NACK = 8'h15;
  localparam logic [7:0] POS_ID   = 8'h33;
  localparam logic [7:0] POS_LEN  = 8'd67;

  // frame byte limit: a frame reaching this many bytes, checksum byte included, is aborted
  localparam int MAX_FRAME_BYTES = 256;
  // the byte count is 8 bits wide, so a frame never grows past 255 bytes
  localparam int FRAME_LIMIT_INT = (MAX_FRAME_BYTES > 256) ? 256 : MAX_FRAME_BYTES;
  localparam logic [8:0] FRAME_LIMIT = 9'(FRAME_LIMIT_INT);

  localparam int TDATA_W = 40;
  localparam int TUSER_W = 2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NACK = 2'd2,
    REPLY_RSVD = 2'd3
  } reply_t;

  typedef struct packed {
    logic       position_ready;
    logic [7:0] reply_id;
    reply_t     reply;
    logic [7:0] frame_length;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    kind_t      kind;
  } result_t;

endpackage

// ===== src/dle_etx_decode.sv =====
// Frame decoder: DLE/ETX unstuffing, checksum and byte count state.
// Depends on dle_etx_pkg.
module dle_etx_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,       // one byte is processed this cycle
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  output dle_etx_pkg::result_t res
);
  import dle_etx_pkg::*;

  logic [1:0] dle_count, dle_count_next;
  logic       escape_pending, escape_pending_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] stored_count, stored_count_next;
  logic [7:0] frame_id, frame_id_next;

  logic [1:0] dle_inc;
  logic [8:0] count_inc;
  logic       is_dle, is_etx, empty, good, is_reply;

  assign is_dle    = (rx_byte == SYM_DLE);
  assign is_etx    = (rx_byte == SYM_ETX);
  assign empty     = (stored_count == 8'd0);
  assign dle_inc   = (dle_count == 2'd3) ? dle_count : dle_count + 2'd1;
  assign count_inc = {1'b0, stored_count} + 9'd1;
  assign good      = (running_sum == 8'd0);
  assign is_reply  = (frame_id == SYM_ACK) || (frame_id == SYM_NACK);

  // byte step
  always_comb begin
    dle_count_next      = dle_count;
    escape_pending_next = escape_pending;
    running_sum_next    = running_sum;
    stored_count_next   = stored_count;
    frame_id_next       = frame_id;
    res_valid           = 1'b0;
    res                 = '0;
    if (is_dle && (dle_inc == 2'd1)) begin
      // start of frame
      dle_count_next = dle_inc;
    end else if (is_dle && empty && (dle_inc == 2'd2)) begin
      // empty restart
      dle_count_next      = 2'd0;
      escape_pending_next = 1'b0;
      running_sum_next    = 8'd0;
      stored_count_next   = 8'd0;
    end else if (is_dle && !escape_pending) begin
      // first DLE of an escape
      dle_count_next      = dle_inc;
      escape_pending_next = 1'b1;
    end else if (dle_count == 2'd0 && !is_dle) begin
      // idle line, byte ignored
    end else if (empty && is_etx) begin
      // ETX as id drops the frame
      dle_count_next      = 2'd0;
      escape_pending_next = 1'b0;
      running_sum_next    = 8'd0;
      stored_count_next   = 8'd0;
    end else if (escape_pending && is_etx) begin
      // end of frame verdict
      dle_count_next        = 2'd0;
      escape_pending_next   = 1'b0;
      running_sum_next      = 8'd0;
      stored_count_next     = 8'd0;
      res_valid             = 1'b1;
      res.kind              = good ? KIND_GOOD : KIND_BAD;
      res.frame_length      = stored_count;
      res.reply             = is_reply ? REPLY_NONE : (good ? REPLY_ACK : REPLY_NACK);
      res.reply_id          = frame_id;
      res.position_ready    = good && (frame_id == POS_ID) && (stored_count == POS_LEN);
    end else begin
      // stored data byte, doubled DLE included
      if (is_dle) begin
        dle_count_next = dle_inc;
      end
      escape_pending_next = 1'b0;
      if (empty) begin
        frame_id_next = rx_byte;
      end
      res_valid      = 1'b1;
      res.data_byte  = rx_byte;
      res.byte_index = stored_count;
      if (count_inc >= FRAME_LIMIT) begin
        // overlong frame
        dle_count_next      = 2'd0;
        escape_pending_next = 1'b0;
        running_sum_next    = 8'd0;
        stored_count_next   = 8'd0;
        res.kind            = KIND_ABORT;
        res.frame_length    = count_inc[8] ? 8'hFF : count_inc[7:0];
      end else begin
        running_sum_next  = running_sum + rx_byte;
        stored_count_next = count_inc[7:0];
        res.kind          = KIND_DATA;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dle_count      <= 2'd0;
      escape_pending <= 1'b0;
      running_sum    <= 8'd0;
      stored_count   <= 8'd0;
      frame_id       <= 8'd0;
    end else if (step) begin
      dle_count      <= dle_count_next;
      escape_pending <= escape_pending_next;
      running_sum    <= running_sum_next;
      stored_count   <= stored_count_next;
      frame_id       <= frame_id_next;
    end
  end

  // an idle receiver holds no partial frame
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (dle_count == 2'd0) |-> (stored_count == 8'd0) && !escape_pending)
    else $error("idle receiver holds frame state");

  // an abort or a verdict leaves the receiver idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && (res.kind != KIND_DATA) |=> (dle_count == 2'd0)
      && (stored_count == 8'd0) && (running_sum == 8'd0))
    else $error("receiver not idle after frame end");

  // a data byte grows the count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && (res.kind == KIND_DATA)
      |=> stored_count == $past(stored_count) + 8'd1)
    else $error("byte count did not advance");

endmodule

// ===== src/dle_etx_out_reg.sv =====
// Result register of the frame receiver, with the master-side handshake.
// Depends on dle_etx_pkg.
module dle_etx_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,       // a result is written this cycle
  input  dle_etx_pkg::result_t res,
  output logic                 free,       // slot can take a result now
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output dle_etx_pkg::result_t held
);
  import dle_etx_pkg::*;

  assign free = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

endmodule

// ===== src/dle_etx_frame_receiver.sv =====
// Top level of the DLE/ETX frame receiver: input register, decoder, result register.
// Depends on dle_etx_pkg, dle_etx_decode and dle_etx_out_reg.
//
// Usage: raw bytes from a serial receiver enter on the slave stream, one per
// transaction. Every stored (unescaped) frame byte leaves on the master stream
// with kind 0 in tuser; the end of a frame gives one transaction with kind 1
// (checksum good) or 2 (checksum bad), the frame length, the reply to send and
// the frame id; an overlong frame ends in a kind 3 transaction. Framing bytes
// and idle line bytes give no result.
// An accepted byte passes through the input register, then is decoded into the
// result register, from which its result leaves on the master side.
// Throughput: one byte per cycle while the master side takes results; the decode
// step between the input register and the result register is combinational.
// Reset (rst, synchronous) empties both registers and returns the decoder to
// the idle line state with a zero checksum and byte count.
// When the master side stalls, the result register holds its transaction; the
// input register then takes one more byte and s_tready falls until the result
// is taken.
module dle_etx_frame_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] data_byte, [15:8] byte_index, [23:16] frame_length, [25:24] reply,
  // [33:26] reply_id, [34] position_ready, [39:35] zero
  output logic [dle_etx_pkg::TDATA_W-1:0]   m_tdata,
  output logic [dle_etx_pkg::TUSER_W-1:0]   m_tuser    // [1:0] kind
);
  import dle_etx_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       free;
  logic       res_valid;
  result_t    res;
  result_t    held;

  assign advance  = in_valid && free;
  assign s_tready = !in_valid || free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  dle_etx_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  dle_etx_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .held     (held)
  );

  // output packing
  assign m_tdata = {5'b0, held.position_ready, held.reply_id, held.reply,
                    held.frame_length, held.byte_index, held.data_byte};
  assign m_tuser = held.kind;

  // the input side only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready && in_valid)
    else $error("input stalled without a blocked result");

  // only verdicts carry a reply
  a_reply_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (held.reply != REPLY_NONE)
      |-> (held.kind == KIND_GOOD) || (held.kind == KIND_BAD))
    else $error("reply on a non-verdict result");

endmodule
